// File: sv/aedm_pkg.sv
package aedm_pkg;

	localparam int DELAY_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int INDEX_W     = $clog2(DELAY_DEPTH + 1);

	localparam int SAMPLE_W    = 16;
	localparam int RATE_W      = 18;
	localparam int MS_W        = 10;
	localparam int RATE_DIV_W  = 9;
	localparam int PROD_W      = RATE_DIV_W + MS_W;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every x below 2**18
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 999) / 1000);
	localparam int RECIP_PROD_W = RATE_W + RECIP_W;

	localparam logic [ADDR_W-1:0] DELAY_MAX = ADDR_W'(DELAY_DEPTH - 1);

	localparam logic [RATE_W-1:0]     RATE_RESET     = RATE_W'(44100);
	localparam logic [MS_W-1:0]       MS_RESET       = MS_W'(20);
	localparam logic [RATE_DIV_W-1:0] RATE_DIV_RESET = RATE_DIV_W'(44100 / 1000);
	localparam logic [ADDR_W-1:0]     DELAY_RESET    = ADDR_W'((44100 / 1000) * 20);

	typedef enum logic [0:0] {
		REG_SAMPLE_RATE = 1'b0,
		REG_ECHO_MS     = 1'b1
	} reg_idx_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// File: sv/aedm_in_if.sv
interface aedm_in_if;
	logic                valid;
	logic                ready;
	aedm_pkg::sample_t   in_sample;
	logic                last_sample;

	modport source (output valid, output in_sample, output last_sample, input ready);
	modport sink (input valid, input in_sample, input last_sample, output ready);
endinterface

// File: sv/aedm_out_if.sv
interface aedm_out_if;
	logic                valid;
	logic                ready;
	aedm_pkg::sample_t   out_sample;
	logic                out_last;

	modport source (output valid, output out_sample, output out_last, input ready);
	modport sink (input valid, input out_sample, input out_last, output ready);
endinterface

// File: sv/aedm_cfg.sv
module aedm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aedm_pkg::PADDR_W-1:0]      paddr,
	input  logic [aedm_pkg::PDATA_W-1:0]      pwdata,
	output logic [aedm_pkg::PDATA_W-1:0]      prdata,
	output logic [aedm_pkg::ADDR_W-1:0]       delay
);

	logic [aedm_pkg::RATE_W-1:0]       rate_q;
	logic [aedm_pkg::MS_W-1:0]         ms_q;
	logic [aedm_pkg::RATE_DIV_W-1:0]   rate_div_q;
	logic [aedm_pkg::ADDR_W-1:0]       delay_q;
	logic [aedm_pkg::RECIP_PROD_W-1:0] recip_prod;
	logic [aedm_pkg::PROD_W-1:0]       dly_prod;
	logic                              wr_en;
	aedm_pkg::reg_idx_t                reg_idx;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = aedm_pkg::reg_idx_t'(paddr[2]);

	// rate / 1000 by reciprocal multiply, taken at write time
	assign recip_prod = aedm_pkg::RECIP_PROD_W'(pwdata[aedm_pkg::RATE_W-1:0])
		* aedm_pkg::RECIP_PROD_W'(aedm_pkg::RECIP);
	assign dly_prod = aedm_pkg::PROD_W'(rate_div_q) * aedm_pkg::PROD_W'(ms_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= aedm_pkg::RATE_RESET;
			ms_q       <= aedm_pkg::MS_RESET;
			rate_div_q <= aedm_pkg::RATE_DIV_RESET;
			delay_q    <= aedm_pkg::DELAY_RESET;
		end else begin
			if (wr_en) begin
				unique case (reg_idx)
					aedm_pkg::REG_SAMPLE_RATE: begin
						rate_q     <= pwdata[aedm_pkg::RATE_W-1:0];
						rate_div_q <= recip_prod[aedm_pkg::RECIP_SHIFT +: aedm_pkg::RATE_DIV_W];
					end
					aedm_pkg::REG_ECHO_MS: begin
						ms_q <= pwdata[aedm_pkg::MS_W-1:0];
					end
					default: begin
					end
				endcase
			end
			// clamp to DELAY_MAX, one below the ring depth
			if (dly_prod > aedm_pkg::PROD_W'(aedm_pkg::DELAY_MAX)) begin
				delay_q <= aedm_pkg::DELAY_MAX;
			end else begin
				delay_q <= dly_prod[aedm_pkg::ADDR_W-1:0];
			end
		end
	end

	always_comb begin
		unique case (reg_idx)
			aedm_pkg::REG_SAMPLE_RATE: prdata = aedm_pkg::PDATA_W'(rate_q);
			aedm_pkg::REG_ECHO_MS:     prdata = aedm_pkg::PDATA_W'(ms_q);
			default:                   prdata = '0;
		endcase
	end

	assign delay = delay_q;

endmodule

// File: sv/audio_echo_delay_mix_unit.sv
// audio echo delay mix: adds half of the sample from D positions back
// in_ch takes one request per cycle (in_sample, last_sample) when
// valid and ready are both high; out_ch gives one request per input,
// in order, with out_sample and out_last
// D = (sample_rate / 1000) * echo_delay_ms, clamped to 4095; the first
// D+1 samples of a block pass through unchanged, last_sample restarts
// the block count
// path: an accepted sample moves into the s1 registers, then into the output register
// throughput: one sample per cycle while out_ch is not stalled, set by the
// single ring write and registered ring read done at the accept edge
// stall: an input stage and an output register part the two sides;
// while out_ch is stalled both fill, then in_ch.ready drops
// reset: config returns to 44100 samples/s and 20 ms, pointers and
// block count clear; ring contents are not cleared and are only used
// after being written within the current block
// registers: sample_rate at 0x0, echo_delay_ms at 0x4 over an APB
// port with pready tied high; a new delay applies once the written register, then delay_q, update
module audio_echo_delay_mix_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	aedm_in_if.sink                        in_ch,
	aedm_out_if.source                     out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [aedm_pkg::PADDR_W-1:0]   paddr,
	input  logic [aedm_pkg::PDATA_W-1:0]   pwdata,
	output logic [aedm_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	logic [aedm_pkg::ADDR_W-1:0]   delay;
	logic [aedm_pkg::ADDR_W-1:0]   wp_q;
	logic [aedm_pkg::INDEX_W-1:0]  index_q;
	logic [aedm_pkg::ADDR_W-1:0]   rd_addr;
	logic                          in_fire;
	logic                          advance;

	aedm_pkg::sample_t             ring [aedm_pkg::DELAY_DEPTH];

	logic                          valid_s1;
	aedm_pkg::sample_t             sample_s1;
	aedm_pkg::sample_t             rdata_s1;
	logic                          last_s1;
	logic                          echo_s1;
	logic                          self_s1;

	aedm_pkg::sample_t             past;
	aedm_pkg::sample_t             half;
	aedm_pkg::sample_t             mix;

	logic                          out_valid_q;
	aedm_pkg::sample_t             out_sample_q;
	logic                          out_last_q;

	aedm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.delay   (delay)
	);

	assign pready = 1'b1;

	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign rd_addr     = wp_q - delay;

	// ring: write current sample, read the one D back, both at accept
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ring[wp_q] <= in_ch.in_sample;
			rdata_s1   <= ring[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= in_ch.in_sample;
			last_s1   <= in_ch.last_sample;
			echo_s1   <= index_q > aedm_pkg::INDEX_W'(delay);
			self_s1   <= delay == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wp_q     <= '0;
			index_q  <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				wp_q     <= wp_q + 1'b1;
				if (in_ch.last_sample) begin
					index_q <= '0;
				end else if (index_q < aedm_pkg::INDEX_W'(aedm_pkg::DELAY_DEPTH)) begin
					index_q <= index_q + 1'b1;
				end
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// zero delay reads the sample being written
	assign past = self_s1 ? sample_s1 : rdata_s1;
	// divide by two toward zero
	assign half = (past + aedm_pkg::sample_t'(past[aedm_pkg::SAMPLE_W-1])) >>> 1;
	assign mix  = echo_s1 ? aedm_pkg::sample_t'(sample_s1 + half) : sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_sample_q <= mix;
			out_last_q   <= last_s1;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_sample = out_sample_q;
	assign out_ch.out_last   = out_last_q;

endmodule

// File: tb/audio_echo_delay_mix_unit_tb.sv
`timescale 1ns / 1ps
module audio_echo_delay_mix_unit_tb;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_BLOCK  = 300;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 77;

	typedef struct packed {
		aedm_pkg::sample_t sample;
		logic              last;
	} audio_word_t;

	logic                         clk     = 1'b0;
	logic                         arst_n  = 1'b0;
	logic                         psel    = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite  = 1'b0;
	logic [aedm_pkg::PADDR_W-1:0] paddr   = '0;
	logic [aedm_pkg::PDATA_W-1:0] pwdata  = '0;
	logic [aedm_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	aedm_in_if  in_ch();
	aedm_out_if out_ch();

	audio_echo_delay_mix_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	audio_word_t                 pending_samples[$];
	audio_word_t                 expected_mix[$];
	audio_word_t                 next_word;
	audio_word_t                 want;
	int unsigned                 rate_cfg = 44100;
	int unsigned                 ms_cfg   = 20;
	aedm_pkg::sample_t           history [aedm_pkg::DELAY_DEPTH];
	logic [aedm_pkg::ADDR_W-1:0] write_slot = '0;
	int unsigned                 block_pos  = 0;
	int unsigned                 src_idle_pct  = 9;
	int unsigned                 sink_idle_pct = 75;
	int                          mismatches    = 0;
	int                          quiet_cycles  = 0;
	aedm_pkg::sample_t           corner_samples [11] = '{
		16'sh7fff, -16'sh8000, -16'sd1, -16'sd3, 16'sh7fff, -16'sh8000,
		16'sd0, 16'sd5, 16'sd1, 16'sh7fff, -16'sh8000
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned echo_span(input int unsigned rate, input int unsigned ms);
		int unsigned d;
		d = (rate / 1000) * ms;
		return (d > aedm_pkg::DELAY_DEPTH - 1) ? aedm_pkg::DELAY_DEPTH - 1 : d;
	endfunction

	function automatic aedm_pkg::sample_t rand_sample();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return -16'sh8000;
			2: return aedm_pkg::sample_t'(int'($urandom_range(6)) - 3);
			default: return aedm_pkg::sample_t'($urandom);
		endcase
	endfunction

	function automatic void add_sample(input aedm_pkg::sample_t s, input logic last);
		audio_word_t w;
		w.sample = s;
		w.last   = last;
		pending_samples.push_back(w);
	endfunction

	// echo mixer state follows each accepted request
	task automatic mix_sample(input aedm_pkg::sample_t x, input logic last);
		int unsigned       d;
		aedm_pkg::sample_t past;
		audio_word_t       w;
		d = echo_span(rate_cfg, ms_cfg);
		history[write_slot] = x;
		w.last = last;
		if (block_pos <= d) begin
			w.sample = x;
		end else begin
			past     = history[write_slot - aedm_pkg::ADDR_W'(d)];
			w.sample = aedm_pkg::sample_t'(int'(x) + int'(past) / 2);
		end
		expected_mix.push_back(w);
		write_slot = write_slot + 1'b1;
		if (last) begin
			block_pos = 0;
		end else if (block_pos < aedm_pkg::DELAY_DEPTH) begin
			block_pos++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				mix_sample(in_ch.in_sample, in_ch.last_sample);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					next_word = pending_samples.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.in_sample   <= next_word.sample;
					in_ch.last_sample <= next_word.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_mix.size() == 0) begin
					$error("out_sample %0d arrived with nothing expected", out_ch.out_sample);
					mismatches++;
				end else begin
					want = expected_mix.pop_front();
					if (out_ch.out_sample !== want.sample) begin
						$error("out_sample expected %0d actual %0d", want.sample,
							out_ch.out_sample);
						mismatches++;
					end
					if (out_ch.out_last !== want.last) begin
						$error("out_last expected %0b actual %0b", want.last, out_ch.out_last);
						mismatches++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("audio_echo_delay_mix_unit: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic settle();
		while (pending_samples.size() > 0 || in_ch.valid || expected_mix.size() > 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input aedm_pkg::reg_idx_t idx,
		input logic [aedm_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_echo(input int unsigned rate, input int unsigned ms);
		logic [aedm_pkg::PDATA_W-1:0] word;
		settle();
		word = $urandom;
		word[aedm_pkg::RATE_W-1:0] = rate[aedm_pkg::RATE_W-1:0];
		write_reg(aedm_pkg::REG_SAMPLE_RATE, word);
		word = $urandom;
		word[aedm_pkg::MS_W-1:0] = ms[aedm_pkg::MS_W-1:0];
		write_reg(aedm_pkg::REG_ECHO_MS, word);
		rate_cfg = rate[aedm_pkg::RATE_W-1:0];
		ms_cfg   = ms[aedm_pkg::MS_W-1:0];
		repeat (3) @(negedge clk);
	endtask

	// block lengths are random up to span + 40; phases may cut a block
	task automatic queue_random(input int count, input int unsigned span);
		int len;
		while (count > 0) begin
			case ($urandom_range(9))
				0, 1: len = 1;
				2: len = $urandom_range(8, 2);
				default: len = $urandom_range(span + 40, 1);
			endcase
			for (int i = 0; i < len && count > 0; i++) begin
				add_sample(rand_sample(), i == len - 1);
				count--;
			end
		end
	endtask

	initial begin
		int unsigned rate;
		int unsigned ms;
		in_ch.valid       = 1'b0;
		in_ch.in_sample   = '0;
		in_ch.last_sample = 1'b0;
		out_ch.ready      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings
		for (int i = 0; i < 5; i++)
			add_sample(rand_sample(), i == 4);

		set_echo(1000, 3);
		foreach (corner_samples[i])
			add_sample(corner_samples[i], i == 10);
		add_sample(rand_sample(), 1'b1);

		// rate below 1000 gives zero delay
		set_echo(999, 1023);
		foreach (corner_samples[i])
			add_sample(corner_samples[i], i == 10);

		// clamped delay
		set_echo(262143, 1023);
		for (int i = 0; i < LONG_BLOCK; i++)
			add_sample(rand_sample(), i == LONG_BLOCK - 1);

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES / 3) begin
				src_idle_pct  = 75;
				sink_idle_pct = 9;
			end else if (p == 2 * PHASES / 3) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			case ($urandom_range(3))
				0: begin
					rate = $urandom_range(30000, 1000);
					ms   = $urandom_range(4, 0);
				end
				1: begin
					rate = $urandom_range(1) ? 0 : $urandom_range(999, 0);
					ms   = $urandom_range(1023, 0);
				end
				2: begin
					rate = $urandom_range(2999, 1000);
					ms   = $urandom_range(40, 0);
				end
				default: begin
					rate = $urandom_range(262143, 100000);
					ms   = $urandom_range(1, 0);
				end
			endcase
			set_echo(rate, ms);
			queue_random(PHASE_ITEMS, echo_span(rate, ms));
		end

		settle();
		if (mismatches == 0)
			$display("audio_echo_delay_mix_unit: match");
		else
			$display("audio_echo_delay_mix_unit: mismatch");
		$finish;
	end

endmodule
